/* rtl/assert_macros.svh */
// assertion macros used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside reset
`define CVF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define CVF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/cvf_pkg.sv */
// shared types, codes and arithmetic helpers of the channel vocoder
package cvf_pkg;

  localparam int DEF_MAX_BANDS = 16;

  // configuration register indexes
  localparam logic [2:0] REG_SWAP      = 3'd0;
  localparam logic [2:0] REG_BANDS     = 3'd1;
  localparam logic [2:0] REG_OUT_GAIN  = 3'd2;
  localparam logic [2:0] REG_THRU_GAIN = 3'd3;
  localparam logic [2:0] REG_HIGH_GAIN = 3'd4;
  localparam logic [2:0] REG_FEEDBACK  = 3'd5;

  // reset values
  localparam logic [4:0]         RST_BANDS     = 5'd8;
  localparam logic [31:0]        RST_OUT_GAIN  = 32'd9391;
  localparam logic [31:0]        RST_THRU_GAIN = 32'd8488673;
  localparam logic [31:0]        RST_HIGH_GAIN = 32'd8488673;
  localparam logic signed [31:0] RST_FEEDBACK  = -32'sd513635000;

  // coefficient select codes
  localparam logic [1:0] SEL_RES    = 2'd0;
  localparam logic [1:0] SEL_STAGE2 = 2'd1;
  localparam logic [1:0] SEL_RATE   = 2'd2;

  // rounding shift codes of the multiplier
  localparam logic [1:0] SH_22 = 2'd0;
  localparam logic [1:0] SH_23 = 2'd1;
  localparam logic [1:0] SH_29 = 2'd2;

  localparam int MRES_W = 48;
  localparam int SUM_W  = 52;

  localparam logic signed [31:0] LIMIT_TEN = 32'sd83886080;

  typedef struct packed {
    logic               swap;
    logic [4:0]         band_count;
    logic [31:0]        out_gain;
    logic [31:0]        thru_gain;
    logic [31:0]        high_gain;
    logic signed [31:0] fb;
  } cfg_t;

  function automatic logic signed [SUM_W-1:0] sx32(input logic signed [31:0] v);
    return {{(SUM_W-32){v[31]}}, v};
  endfunction

  function automatic logic signed [SUM_W-1:0] sx48(input logic signed [MRES_W-1:0] v);
    return {{(SUM_W-MRES_W){v[MRES_W-1]}}, v};
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = sx32(32'sh7fffffff);
    lo = sx32(32'sh80000000);
    if (v > hi) return 32'sh7fffffff;
    else if (v < lo) return 32'sh80000000;
    else return v[31:0];
  endfunction

  function automatic logic signed [31:0] abs_sat(input logic signed [31:0] v);
    return sat32(v[31] ? -sx32(v) : sx32(v));
  endfunction

endpackage

/* rtl/cvf_ram.sv */
// generic single write, single read ram with registered read
module cvf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/cvf_mul.sv */
// shared signed multiplier with round-half-up shift, registered result
module cvf_mul import cvf_pkg::*; (
  input  logic                     clk,
  input  logic signed [32:0]       x,
  input  logic signed [32:0]       y,
  input  logic [1:0]               sh,
  output logic signed [MRES_W-1:0] res
);

  logic signed [65:0] prod;
  logic signed [65:0] rnd;

  always_comb begin
    prod = x * y;
    case (sh)
      SH_22:   rnd = (prod + 66'sd2097152) >>> 22;
      SH_23:   rnd = (prod + 66'sd4194304) >>> 23;
      SH_29:   rnd = (prod + 66'sd268435456) >>> 29;
      default: rnd = prod;
    endcase
  end

  always_ff @(posedge clk) begin
    res <= rnd[MRES_W-1:0];
  end

endmodule

/* rtl/cvf_regs.sv */
// configuration registers behind the apb port
module cvf_regs import cvf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [2:0] idx;
  logic       wr;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr     = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.swap       <= 1'b0;
      cfg.band_count <= RST_BANDS;
      cfg.out_gain   <= RST_OUT_GAIN;
      cfg.thru_gain  <= RST_THRU_GAIN;
      cfg.high_gain  <= RST_HIGH_GAIN;
      cfg.fb         <= RST_FEEDBACK;
    end else if (wr) begin
      case (idx)
        REG_SWAP:      cfg.swap       <= pwdata[0];
        REG_BANDS:     cfg.band_count <= pwdata[4:0];
        REG_OUT_GAIN:  cfg.out_gain   <= pwdata;
        REG_THRU_GAIN: cfg.thru_gain  <= pwdata;
        REG_HIGH_GAIN: cfg.high_gain  <= pwdata;
        REG_FEEDBACK:  cfg.fb         <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SWAP:      prdata = {31'd0, cfg.swap};
      REG_BANDS:     prdata = {27'd0, cfg.band_count};
      REG_OUT_GAIN:  prdata = cfg.out_gain;
      REG_THRU_GAIN: prdata = cfg.thru_gain;
      REG_HIGH_GAIN: prdata = cfg.high_gain;
      REG_FEEDBACK:  prdata = cfg.fb;
      default:       prdata = 32'd0;
    endcase
  end

endmodule

/* rtl/channel_vocoder_filter_bank.sv */
// channel vocoder top level: sequencer, datapath and band state memory
//
// input stream: one request per cycle at most, accepted on s_tvalid && s_tready.
//   s_tuser = 0 carries an audio pair, s_tuser = 1 writes one band coefficient.
//   a coefficient request gives no result and the block is ready again next cycle.
// output stream: one out_sample per audio request, held in an output register
//   until m_tready; the block already takes the next request while it waits.
// sequencing: audio on odd phase skips the band bank; on even phase the band
//   bank runs too, when two or more bands are set. the steps are serialized
//   by the single shared multiplier, used about eight times per band section pair
//   plus envelope and band weighting. s_tready is low while a sample is worked on.
// band filter state lives in a ram, one row of eight words per band; per-row
//   valid bits make an unwritten or cleared row read as zero.
// reset: synchronous, clears all signal state and the valid bits at once, loads
//   the register defaults; coefficients stay undefined until written.
// an output whose magnitude is above ten clears all signal state as it is sent.
// a stalled receiver holds m_tdata; the next result waits in the sequencer.
module channel_vocoder_filter_bank import cvf_pkg::*; #(
  parameter int MAX_BANDS = DEF_MAX_BANDS
) (
  input  logic        clk,
  input  logic        rst,
  // apb configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  // modulator_sample[23:0], carrier_sample[47:24], coef_band[51:48],
  // coef_select[53:52], coef_value[85:54], zero pad[87:86]
  input  logic [87:0] s_tdata,
  // command[0]
  input  logic        s_tuser,
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  // out_sample[31:0]
  output logic [31:0] m_tdata
);

  localparam int BW = $clog2(MAX_BANDS);
  localparam logic [5:0] MAXB = 6'(MAX_BANDS);

  // sequencer states
  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_PRE  = 5'd1;
  localparam logic [4:0] ST_MAG  = 5'd2;
  localparam logic [4:0] ST_HD   = 5'd3;
  localparam logic [4:0] ST_HM   = 5'd4;
  localparam logic [4:0] ST_HE   = 5'd5;
  localparam logic [4:0] ST_X1   = 5'd6;
  localparam logic [4:0] ST_X2   = 5'd7;
  localparam logic [4:0] ST_X3   = 5'd8;
  localparam logic [4:0] ST_X4   = 5'd9;
  localparam logic [4:0] ST_BRD  = 5'd10;
  localparam logic [4:0] ST_BLD  = 5'd11;
  localparam logic [4:0] ST_M1   = 5'd12;
  localparam logic [4:0] ST_M2   = 5'd13;
  localparam logic [4:0] ST_M3   = 5'd14;
  localparam logic [4:0] ST_M4   = 5'd15;
  localparam logic [4:0] ST_M5   = 5'd16;
  localparam logic [4:0] ST_E0   = 5'd17;
  localparam logic [4:0] ST_E1   = 5'd18;
  localparam logic [4:0] ST_E2   = 5'd19;
  localparam logic [4:0] ST_E3   = 5'd20;
  localparam logic [4:0] ST_E4   = 5'd21;
  localparam logic [4:0] ST_E5   = 5'd22;
  localparam logic [4:0] ST_BEND = 5'd23;
  localparam logic [4:0] ST_SUM  = 5'd24;
  localparam logic [4:0] ST_FIN  = 5'd25;
  localparam logic [4:0] ST_OUT  = 5'd26;

  cfg_t cfg;

  logic [4:0] state;

  // signal state
  logic signed [31:0] mod_prev, car_prev, henv;
  logic signed [31:0] mzd0, mzd1, czd0, czd1;
  logic               phase;
  logic signed [31:0] held;
  logic signed [31:0] env [MAX_BANDS];
  logic [MAX_BANDS-1:0] vld;

  // coefficients, undefined until written
  logic signed [31:0] c_res  [MAX_BANDS];
  logic signed [31:0] c_st2  [MAX_BANDS];
  logic signed [31:0] c_rate [MAX_BANDS];

  // working registers
  logic signed [31:0] ra, rb, ad, bd, aa, bb;
  logic signed [31:0] mag, dd, tt, cbv, mbv, o;
  logic signed [MRES_W-1:0] tmp;
  logic signed [SUM_W-1:0]  acc;
  logic signed [31:0] st [8];
  logic [BW-1:0] band;
  logic          ch;
  logic          out_valid;
  logic [31:0]   out_data;

  // shared multiplier
  logic signed [32:0]       mx, my;
  logic [1:0]               msh;
  logic signed [MRES_W-1:0] mres;

  // band state ram
  logic             ram_we;
  logic [255:0]     ram_wdata, ram_rdata;

  logic        acc_in;
  logic [5:0]  cb_ext;
  logic [BW-1:0] cb_idx;
  logic [BW-1:0] last_band;
  logic        bank_on;
  logic signed [31:0] sec_in;
  logic signed [31:0] sec_u;
  logic signed [31:0] fin_o;
  logic        clr;
  logic [2:0]  k0, k1, k2, k3;

  cvf_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  cvf_mul u_mul (.clk(clk), .x(mx), .y(my), .sh(msh), .res(mres));

  cvf_ram #(.WIDTH(256), .DEPTH(MAX_BANDS)) u_ram (
    .clk(clk), .we(ram_we), .waddr(band), .wdata(ram_wdata),
    .raddr(band), .rdata(ram_rdata)
  );

  assign s_tready = (state == ST_IDLE);
  assign acc_in   = s_tvalid & s_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  assign cb_ext = {2'd0, s_tdata[51:48]};
  assign cb_idx = cb_ext[BW-1:0];

  // last band in use, clipped to the bank size
  always_comb begin
    logic [5:0] lb;
    lb = ({1'b0, cfg.band_count} > MAXB) ? MAXB - 6'd1 : {1'b0, cfg.band_count} - 6'd1;
    last_band = lb[BW-1:0];
  end
  assign bank_on = (cfg.band_count >= 5'd2);

  // word slots of the current channel within the band row
  assign k0 = {ch, 2'd0};
  assign k1 = {ch, 2'd1};
  assign k2 = {ch, 2'd2};
  assign k3 = {ch, 2'd3};

  assign sec_in = ch ? aa : bb;
  assign sec_u  = sat32(sx32(tt) + sx48(tmp) + sx48(mres));
  assign fin_o  = sat32(sx32(o) + sx48(mres));
  assign clr    = (state == ST_OUT) && (!out_valid || m_tready) &&
                  ((o > LIMIT_TEN) || (o < -LIMIT_TEN));

  assign ram_we = (state == ST_E3);
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      ram_wdata[32*k +: 32] = st[k];
    end
  end

  // operand selection of the shared multiplier
  always_comb begin
    mx  = 33'sd0;
    my  = 33'sd0;
    msh = SH_29;
    case (state)
      ST_HM: begin
        mx = {c_rate[0][31], c_rate[0]}; my = {dd[31], dd}; msh = SH_29;
      end
      ST_HE: begin
        mx = {ad[31], ad}; my = {1'b0, cfg.thru_gain}; msh = SH_22;
      end
      ST_X1: begin
        mx = {bd[31], bd}; my = {1'b0, cfg.high_gain}; msh = SH_22;
      end
      ST_X3: begin
        mx = {henv[31], henv}; my = {tt[31], tt}; msh = SH_23;
      end
      ST_M1: begin
        mx = {c_res[band][31], c_res[band]}; my = {st[k0][31], st[k0]}; msh = SH_29;
      end
      ST_M2: begin
        mx = {cfg.fb[31], cfg.fb}; my = {st[k1][31], st[k1]}; msh = SH_29;
      end
      ST_M3: begin
        mx = {c_st2[band][31], c_st2[band]}; my = {st[k2][31], st[k2]}; msh = SH_29;
      end
      ST_M4: begin
        mx = {cfg.fb[31], cfg.fb}; my = {st[k3][31], st[k3]}; msh = SH_29;
      end
      ST_E2: begin
        mx = {c_rate[band][31], c_rate[band]}; my = {dd[31], dd}; msh = SH_29;
      end
      ST_E4: begin
        mx = {cbv[31], cbv}; my = {env[band][31], env[band]}; msh = SH_23;
      end
      ST_SUM: begin
        mx = {held[31], held}; my = {1'b0, cfg.out_gain}; msh = SH_22;
      end
      default: ;
    endcase
  end

  // coefficient stores
  always_ff @(posedge clk) begin
    if (acc_in && s_tuser && (cb_ext < MAXB)) begin
      case (s_tdata[53:52])
        SEL_RES:    c_res[cb_idx]  <= s_tdata[85:54];
        SEL_STAGE2: c_st2[cb_idx]  <= s_tdata[85:54];
        SEL_RATE:   c_rate[cb_idx] <= s_tdata[85:54];
        default: ;
      endcase
    end
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // output register: loaded when the sequencer hands over, freed on m_tready
      if ((state == ST_OUT) && (!out_valid || m_tready)) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (acc_in && !s_tuser) state <= ST_PRE;
        end
        ST_PRE:  state <= ST_MAG;
        ST_MAG:  state <= ST_HD;
        ST_HD:   state <= ST_HM;
        ST_HM:   state <= ST_HE;
        ST_HE:   state <= ST_X1;
        ST_X1:   state <= ST_X2;
        ST_X2:   state <= ST_X3;
        ST_X3:   state <= ST_X4;
        ST_X4: begin
          if (!phase) state <= bank_on ? ST_BRD : ST_BEND;
          else state <= ST_SUM;
        end
        ST_BRD:  state <= ST_BLD;
        ST_BLD:  state <= ST_M1;
        ST_M1:   state <= ST_M2;
        ST_M2:   state <= ST_M3;
        ST_M3:   state <= ST_M4;
        ST_M4:   state <= ST_M5;
        ST_M5:   state <= ch ? ST_E0 : ST_M1;
        ST_E0:   state <= ST_E1;
        ST_E1:   state <= ST_E2;
        ST_E2:   state <= ST_E3;
        ST_E3:   state <= ST_E4;
        ST_E4:   state <= ST_E5;
        ST_E5:   state <= (band == last_band) ? ST_BEND : ST_BRD;
        ST_BEND: state <= ST_SUM;
        ST_SUM:  state <= ST_FIN;
        ST_FIN:  state <= ST_OUT;
        ST_OUT: begin
          if (!out_valid || m_tready) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // signal state with reset and instability clear
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      mod_prev <= '0;
      car_prev <= '0;
      henv     <= '0;
      mzd0     <= '0;
      mzd1     <= '0;
      czd0     <= '0;
      czd1     <= '0;
      phase    <= 1'b0;
      held     <= '0;
      vld      <= '0;
      for (int i = 0; i < MAX_BANDS; i++) begin
        env[i] <= '0;
      end
    end else begin
      case (state)
        ST_PRE: begin
          mod_prev <= ra;
          car_prev <= rb;
        end
        ST_HE: henv <= sat32(sx32(henv) - sx48(mres));
        ST_X4: begin
          if (!phase) begin
            mzd1 <= mzd0;
            mzd0 <= ad;
            czd1 <= czd0;
            czd0 <= rb;
          end
        end
        ST_E3: begin
          env[band] <= sat32(sx32(env[band]) - sx48(mres));
          vld[band] <= 1'b1;
        end
        ST_BEND: held <= sat32(acc);
        ST_OUT: begin
          if (!out_valid || m_tready) phase <= ~phase;
        end
        default: ;
      endcase
    end
  end

  // datapath working registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (acc_in) begin
          if (cfg.swap) begin
            ra <= {{8{s_tdata[47]}}, s_tdata[47:24]};
            rb <= {{8{s_tdata[23]}}, s_tdata[23:0]};
          end else begin
            ra <= {{8{s_tdata[23]}}, s_tdata[23:0]};
            rb <= {{8{s_tdata[47]}}, s_tdata[47:24]};
          end
        end
      end
      ST_PRE: begin
        ad <= sat32(sx32(ra) - sx32(mod_prev));
        bd <= sat32(sx32(rb) - sx32(car_prev));
      end
      ST_MAG: mag <= abs_sat(ad);
      ST_HD:  dd  <= sat32(sx32(henv) - sx32(mag));
      ST_X1:  tmp <= mres;
      ST_X2:  tt  <= sat32(sx48(tmp) + sx48(mres));
      ST_X4: begin
        o   <= sat32(sx48(mres));
        acc <= '0;
        band <= BW'(1);
        aa  <= sat32(sx32(ad) + sx32(mzd1) - (sx32(mzd0) <<< 1));
        bb  <= sat32(sx32(rb) + sx32(czd1) - (sx32(czd0) <<< 1));
      end
      ST_BLD: begin
        ch <= 1'b0;
        for (int k = 0; k < 8; k++) begin
          st[k] <= vld[band] ? ram_rdata[32*k +: 32] : 32'd0;
        end
      end
      ST_M2: tmp <= mres;
      ST_M3: tt  <= sat32(sx48(tmp) + sx48(mres) + sx32(sec_in));
      ST_M4: tmp <= mres;
      ST_M5: begin
        st[k0] <= tt;
        st[k1] <= st[k0];
        st[k2] <= sec_u;
        st[k3] <= st[k2];
        if (ch) mbv <= sec_u;
        else cbv <= sec_u;
        ch <= 1'b1;
      end
      ST_E0: mag <= abs_sat(mbv);
      ST_E1: dd  <= sat32(sx32(env[band]) - sx32(mag));
      ST_E5: begin
        acc  <= acc + sx32(sat32(sx48(mres)));
        band <= band + BW'(1);
      end
      ST_FIN: o <= fin_o;
      ST_OUT: begin
        if (!out_valid || m_tready) out_data <= o;
      end
      default: ;
    endcase
  end

endmodule

/* rtl/cvf_checker.sv */
// port-level checker of the channel vocoder, bound to the top level
`include "assert_macros.svh"

module cvf_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  `CVF_ASSERT_ALWAYS(a_rst_no_out, rst |=> !m_tvalid, "result valid after reset")
  `CVF_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled result changed")
  `CVF_ASSERT(a_cmd_no_out, s_tvalid && s_tready && s_tuser && !m_tvalid |=> !m_tvalid, "command gave a result")
  `CVF_ASSERT(a_busy, s_tvalid && s_tready && !s_tuser |=> !s_tready, "ready during sample work")

endmodule

bind channel_vocoder_filter_bank cvf_checker u_cvf_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
